@@ design/md4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and round tables for the MD4 digest block.
// ----------------------------------------------------------------------------
package md4_pkg;

  // initial chaining vector
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  // additive constants of the second and third pass
  localparam logic [31:0] K_G = 32'h5A827999;
  localparam logic [31:0] K_H = 32'h6ED9EBA1;

  // padding marker byte and block geometry
  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] POS_LAST  = 6'h3F;
  localparam logic [2:0] LEN_SLOT  = 3'd7;   // pos[5:3] of the length field
  localparam logic [5:0] RND_LAST  = 6'd48;  // sequencer step of the last round
  localparam logic [5:0] FOLD_STEP = 6'd49;  // sequencer step of the chain add

  // byte source for a buffer write
  typedef enum logic [1:0] {
    SRC_IN   = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } src_t;

  // controller to datapath commands
  typedef struct packed {
    logic       wr;        // write one byte at the position, advance it
    src_t       src;
    logic       add_byte;  // count one message byte
    logic       load;      // working words from chaining words
    logic       rd_en;     // read one message word
    logic [3:0] rd_word;
    logic       rnd_en;    // run one round on the read word
    logic [5:0] rnd;
    logic       fold;      // add working words into chaining words
    logic       latch;     // copy digest out, restart the message
    logic [1:0] out_idx;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [5:0] pos;
  } sts_t;

  // message word used by a round
  function automatic logic [3:0] word_order(input logic [5:0] rnd);
    logic [3:0] i;
    i = rnd[3:0];
    case (rnd[5:4])
      2'd0:    word_order = i;
      2'd1:    word_order = {i[1:0], i[3:2]};
      2'd2:    word_order = {i[0], i[1], i[2], i[3]};
      default: word_order = 4'd0;
    endcase
  endfunction

  // left rotate amount of a round
  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    case ({rnd[5:4], rnd[1:0]})
      4'b0000: rot_amt = 5'd3;
      4'b0001: rot_amt = 5'd7;
      4'b0010: rot_amt = 5'd11;
      4'b0011: rot_amt = 5'd19;
      4'b0100: rot_amt = 5'd3;
      4'b0101: rot_amt = 5'd5;
      4'b0110: rot_amt = 5'd9;
      4'b0111: rot_amt = 5'd13;
      4'b1000: rot_amt = 5'd3;
      4'b1001: rot_amt = 5'd9;
      4'b1010: rot_amt = 5'd11;
      4'b1011: rot_amt = 5'd15;
      default: rot_amt = 5'd0;
    endcase
  endfunction

endpackage

@@ design/md4_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_dp
// Datapath: block buffer, byte position, byte count, round unit,
// chaining words and digest holding registers.
// ----------------------------------------------------------------------------
module md4_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  md4_pkg::cmd_t cmd,
  output md4_pkg::sts_t sts,
  input  logic [7:0]    in_data_byte,
  output logic [31:0]   out_digest_word
);

  logic [31:0] buf_mem [16];
  logic [31:0] rdata_r;
  logic [5:0]  pos_r;
  logic [60:0] byte_cnt_r;
  logic [31:0] chain_r [4];
  logic [31:0] dig_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;

  logic [7:0]  wr_byte;
  logic [63:0] len_bits;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] t_val;

  // byte to store
  assign len_bits = {byte_cnt_r, 3'b000};
  always_comb begin
    case (cmd.src)
      md4_pkg::SRC_IN:   wr_byte = in_data_byte;
      md4_pkg::SRC_MARK: wr_byte = md4_pkg::PAD_MARK;
      md4_pkg::SRC_LEN:  wr_byte = len_bits[8*pos_r[2:0] +: 8];
      default:           wr_byte = 8'h00;
    endcase
  end

  // block buffer, byte write and registered word read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      buf_mem[pos_r[5:2]][8*pos_r[1:0] +: 8] <= wr_byte;
    end
    if (cmd.rd_en) begin
      rdata_r <= buf_mem[cmd.rd_word];
    end
  end

  // round function
  always_comb begin
    case (cmd.rnd[5:4])
      2'd0: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = 32'h0;
      end
      2'd1: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = md4_pkg::K_G;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = md4_pkg::K_H;
      end
    endcase
    sum   = a_r + f_val + k_val + rdata_r;
    dbl   = {sum, sum} << md4_pkg::rot_amt(cmd.rnd);
    t_val = dbl[63:32];
  end

  // working words
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (cmd.rnd_en) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= t_val;
    end
  end

  // position, byte count and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      byte_cnt_r <= '0;
      chain_r[0] <= md4_pkg::IV_A;
      chain_r[1] <= md4_pkg::IV_B;
      chain_r[2] <= md4_pkg::IV_C;
      chain_r[3] <= md4_pkg::IV_D;
    end else begin
      if (cmd.wr) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.add_byte) begin
        byte_cnt_r <= byte_cnt_r + 61'd1;
      end
      if (cmd.fold) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
      if (cmd.latch) begin
        pos_r      <= '0;
        byte_cnt_r <= '0;
        chain_r[0] <= md4_pkg::IV_A;
        chain_r[1] <= md4_pkg::IV_B;
        chain_r[2] <= md4_pkg::IV_C;
        chain_r[3] <= md4_pkg::IV_D;
      end
    end
  end

  // digest holding registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      dig_r <= chain_r;
    end
  end

  assign out_digest_word = dig_r[cmd.out_idx];
  assign sts.pos         = pos_r;

endmodule

@@ design/md4_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_ctrl
// Controller: byte intake, padding sequence, round sequencer and the
// result channel handshake.
// ----------------------------------------------------------------------------
module md4_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_byte_valid,
  input  logic          in_is_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_word_index,
  output logic          out_is_last_word,
  output md4_pkg::cmd_t cmd,
  input  md4_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_FIN
  } ret_t;

  state_t     state_r, state_nxt;
  ret_t       ret_r, ret_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       mark_r, mark_nxt;
  logic       len_ok_r, len_ok_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_idx_r, out_idx_nxt;
  logic       in_acc;
  logic       len_slot;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign len_slot = (sts.pos[5:3] == md4_pkg::LEN_SLOT);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    mark_nxt      = mark_r;
    len_ok_nxt    = len_ok_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    cmd           = '0;
    cmd.out_idx   = out_idx_r;

    // result request drain
    if (out_valid_r && out_ready) begin
      if (out_idx_r == 2'd3) begin
        out_valid_nxt = 1'b0;
      end else begin
        out_idx_nxt = out_idx_r + 2'd1;
      end
    end

    case (state_r)
      S_IDLE: begin
        mark_nxt   = 1'b0;
        len_ok_nxt = 1'b0;
        cnt_nxt    = '0;
        if (in_acc) begin
          if (in_byte_valid) begin
            cmd.wr       = 1'b1;
            cmd.src      = md4_pkg::SRC_IN;
            cmd.add_byte = 1'b1;
            if (sts.pos == md4_pkg::POS_LAST) begin
              state_nxt = S_COMP;
              ret_nxt   = in_is_last ? RET_PAD : RET_IDLE;
            end else if (in_is_last) begin
              state_nxt = S_PAD;
            end
          end else if (in_is_last) begin
            state_nxt = S_PAD;
          end
        end
      end

      // one padding byte per cycle
      S_PAD: begin
        cmd.wr = 1'b1;
        if (!mark_r) begin
          cmd.src    = md4_pkg::SRC_MARK;
          mark_nxt   = 1'b1;
          len_ok_nxt = !len_slot;
        end else if (len_ok_r && len_slot) begin
          cmd.src = md4_pkg::SRC_LEN;
        end else begin
          cmd.src = md4_pkg::SRC_ZERO;
        end
        if (sts.pos == md4_pkg::POS_LAST) begin
          state_nxt  = S_COMP;
          cnt_nxt    = '0;
          len_ok_nxt = 1'b1;
          ret_nxt    = (cmd.src == md4_pkg::SRC_LEN) ? RET_FIN : RET_PAD;
        end
      end

      // load, 48 rounds with word prefetch, chain add
      S_COMP: begin
        cmd.load    = (cnt_r == 6'd0);
        cmd.rd_en   = (cnt_r < md4_pkg::RND_LAST);
        cmd.rd_word = md4_pkg::word_order(cnt_r);
        cmd.rnd_en  = (cnt_r != 6'd0) && (cnt_r <= md4_pkg::RND_LAST);
        cmd.rnd     = cnt_r - 6'd1;
        cnt_nxt     = cnt_r + 6'd1;
        if (cnt_r == md4_pkg::FOLD_STEP) begin
          cmd.fold = 1'b1;
          cnt_nxt  = '0;
          case (ret_r)
            RET_PAD: state_nxt = S_PAD;
            RET_FIN: state_nxt = S_FIN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // hand the digest over once the result channel is free
      S_FIN: begin
        if (!out_valid_r) begin
          cmd.latch     = 1'b1;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 2'd0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_IDLE;
      cnt_r       <= '0;
      mark_r      <= 1'b0;
      len_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      mark_r      <= mark_nxt;
      len_ok_r    <= len_ok_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_index   = out_idx_r;
  assign out_is_last_word = (out_idx_r == 2'd3);

endmodule

@@ design/md4_message_digest.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_message_digest
// MD4 digest of a byte stream, four 32-bit words A..D per message.
// ----------------------------------------------------------------------------
//  channel  handshake           payload
//  in_      in_valid/in_ready   in_data_byte, in_byte_valid, in_is_last
//  out_     out_valid/out_ready out_digest_word, out_word_index,
//                               out_is_last_word
//
//  one request per cycle while a block fills; the 64th byte of a block
//  holds in_ready low for the load, 48 rounds and chain add
//  a closing request writes padding one byte per cycle up to the next
//  block end (9 to 72 bytes), pausing for the load, rounds and chain add
//  of each padded block, then moves the digest to the result registers
//  the digest drains while the next message streams in; a second digest
//  waits until the previous one is fully taken
//  synchronous reset restores the initial vector and clears all counters
// ----------------------------------------------------------------------------
module md4_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_is_last_word
);

  md4_pkg::cmd_t cmd;
  md4_pkg::sts_t sts;

  // sequencer
  md4_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_valid    (in_byte_valid),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_index   (out_word_index),
    .out_is_last_word (out_is_last_word),
    .cmd              (cmd),
    .sts              (sts)
  );

  // buffer and round unit
  md4_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_data_byte    (in_data_byte),
    .out_digest_word (out_digest_word)
  );

endmodule

@@ design/md4_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md4_chk
// Port level checks of the digest result sequence.
// ----------------------------------------------------------------------------
module md4_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [1:0]  out_word_index,
  input logic        out_is_last_word
);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("result request changed while stalled");

  // words of a digest follow back to back in order
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_is_last_word |=>
      out_valid && (out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest word sequence broken");

  // last word flag marks word D
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_last_word == (out_word_index == 2'd3)))
    else $error("last word flag mismatch");

  // a digest starts at word A
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == 2'd0))
    else $error("digest did not start at word A");

  // no result request right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request after reset");

endmodule

bind md4_message_digest md4_chk u_chk (.*);
